// ----- rtl/hse_pkg.sv -----
`default_nettype none

package hse_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EXT_RD,
        ST_EXT_SWAP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } hse_state_t;

    typedef enum logic [1:0] {
        RD_NODE,
        RD_CHILD,
        RD_ROOT_END,
        RD_OUT
    } rd_mode_t;

    typedef struct packed {
        logic     load_key;
        logic     start_sort;
        logic     rd_en;
        rd_mode_t rd_mode;
        logic     node_load;
        logic     sift_step;
        logic     i_dec;
        logic     i_total;
        logic     i_clear;
        logic     i_inc;
        logic     ext_swap;
        logic     out_load;
        logic     set_clear;
    } hse_cmd_t;

    typedef struct packed {
        logic single;
        logic stop;
        logic i_one;
        logic i_two;
        logic final_item;
    } hse_stat_t;

endpackage

`default_nettype wire

// ----- rtl/hse_ctrl.sv -----
`default_nettype none

module hse_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tlast,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire hse_pkg::hse_stat_t stat,
    output hse_pkg::hse_cmd_t       cmd
);
    import hse_pkg::*;

    hse_state_t state_reg, state_next;
    logic       ext_reg, ext_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ext_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ext_reg   <= ext_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ext_next   = ext_reg;
        unique case (state_reg)
            ST_LOAD: begin
                ext_next = 1'b0;
                if (s_tvalid && s_tlast) begin
                    state_next = stat.single ? ST_OUT_RD : ST_BLD_RD;
                end
            end
            ST_BLD_RD:   state_next = ST_BLD_LD;
            ST_BLD_LD:   state_next = ST_SIFT_RD;
            ST_SIFT_RD:  state_next = ST_SIFT_CMP;
            ST_SIFT_CMP: begin
                if (!stat.stop) begin
                    state_next = ST_SIFT_RD;
                end else if (!ext_reg) begin
                    if (stat.i_one) begin
                        ext_next   = 1'b1;
                        state_next = ST_EXT_RD;
                    end else begin
                        state_next = ST_BLD_RD;
                    end
                end else begin
                    state_next = stat.i_two ? ST_OUT_RD : ST_EXT_RD;
                end
            end
            ST_EXT_RD:   state_next = ST_EXT_SWAP;
            ST_EXT_SWAP: state_next = ST_SIFT_RD;
            ST_OUT_RD:   state_next = ST_OUT_LD;
            ST_OUT_LD:   state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (m_tready) begin
                    state_next = stat.final_item ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_key   = 1'b1;
                    cmd.start_sort = s_tlast;
                end
            end
            ST_BLD_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_NODE;
            end
            ST_BLD_LD:   cmd.node_load = 1'b1;
            ST_SIFT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_CHILD;
            end
            ST_SIFT_CMP: begin
                cmd.sift_step = 1'b1;
                if (stat.stop) begin
                    if (!ext_reg) begin
                        cmd.i_total = stat.i_one;
                        cmd.i_dec   = !stat.i_one;
                    end else begin
                        cmd.i_clear = stat.i_two;
                        cmd.i_dec   = !stat.i_two;
                    end
                end
            end
            ST_EXT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_ROOT_END;
            end
            ST_EXT_SWAP: cmd.ext_swap = 1'b1;
            ST_OUT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_OUT;
            end
            ST_OUT_LD:   cmd.out_load = 1'b1;
            ST_OUT_HOLD: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.set_clear = stat.final_item;
                    cmd.i_inc     = !stat.final_item;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/hse_dpath.sv -----
`default_nettype none

module hse_dpath #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BYTES = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [63:0]       s_key,
    input  wire hse_pkg::hse_cmd_t cmd,
    output hse_pkg::hse_stat_t     stat,
    output logic [63:0]            m_key,
    output logic                   m_final,
    output logic                   m_overflow
);
    import hse_pkg::*;

    localparam int KW    = 8 * KEY_BYTES;
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = AW + 2;
    localparam int DEPTH = 2 ** AW;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    logic [KW-1:0] mem [0:DEPTH-1];

    logic [CW-1:0] fill_reg, fill_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] heap_n_reg, heap_n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [KW-1:0] v_reg, v_next;
    logic [KW-1:0] rd_a_reg, rd_b_reg;
    logic [63:0]   m_key_reg;
    logic          m_final_reg, m_overflow_reg;

    logic          full;
    logic [CW-1:0] n_new;
    logic [CW-1:0] i_m1;
    logic [IW-1:0] lc, rc, heap_n_ext;
    logic          lc_ok, rc_ok, take_l, take_r;
    logic [KW-1:0] child;
    logic [AW-1:0] ra, rb, wa;
    logic [KW-1:0] wd;
    logic          we;

    assign full       = (fill_reg == CAP_C);
    assign n_new      = full ? fill_reg : fill_reg + ONE_C;
    assign i_m1       = i_reg - ONE_C;
    assign lc         = {1'b0, pos_reg, 1'b0} + IW'(1);
    assign rc         = {1'b0, pos_reg, 1'b0} + IW'(2);
    assign heap_n_ext = IW'(heap_n_reg);
    assign lc_ok      = (lc < heap_n_ext);
    assign rc_ok      = (rc < heap_n_ext);
    assign take_l     = lc_ok && (rd_a_reg > v_reg);
    assign take_r     = rc_ok && (take_l ? (rd_b_reg > rd_a_reg) : (rd_b_reg > v_reg));
    assign child      = take_r ? rd_b_reg : rd_a_reg;

    assign stat.single     = (n_new == ONE_C);
    assign stat.stop       = !take_l && !take_r;
    assign stat.i_one      = (i_reg == ONE_C);
    assign stat.i_two      = (i_reg == TWO_C);
    assign stat.final_item = ((i_reg + ONE_C) == total_reg);

    always_comb begin
        ra = '0;
        rb = '0;
        unique case (cmd.rd_mode)
            RD_NODE:     ra = i_m1[AW-1:0];
            RD_CHILD: begin
                ra = lc[AW-1:0];
                rb = rc[AW-1:0];
            end
            RD_ROOT_END: rb = i_m1[AW-1:0];
            RD_OUT:      ra = i_reg[AW-1:0];
            default: begin
                ra = '0;
                rb = '0;
            end
        endcase
    end

    always_comb begin
        we = 1'b0;
        wa = pos_reg;
        wd = v_reg;
        if (cmd.load_key && !full) begin
            we = 1'b1;
            wa = fill_reg[AW-1:0];
            wd = s_key[KW-1:0];
        end else if (cmd.sift_step) begin
            we = 1'b1;
            wa = pos_reg;
            wd = (take_l || take_r) ? child : v_reg;
        end else if (cmd.ext_swap) begin
            we = 1'b1;
            wa = i_m1[AW-1:0];
            wd = rd_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en) begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
    end

    always_comb begin
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        total_next  = total_reg;
        heap_n_next = heap_n_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        v_next      = v_reg;
        if (cmd.load_key) begin
            if (full) begin
                drop_next = 1'b1;
            end else begin
                fill_next = fill_reg + ONE_C;
            end
        end
        if (cmd.start_sort) begin
            total_next  = n_new;
            heap_n_next = n_new;
            i_next      = n_new >> 1;
        end
        if (cmd.node_load) begin
            pos_next = i_m1[AW-1:0];
            v_next   = rd_a_reg;
        end
        if (cmd.sift_step && !stat.stop) begin
            pos_next = take_r ? rc[AW-1:0] : lc[AW-1:0];
        end
        if (cmd.ext_swap) begin
            pos_next    = '0;
            v_next      = rd_b_reg;
            heap_n_next = i_m1;
        end
        if (cmd.i_dec) begin
            i_next = i_m1;
        end
        if (cmd.i_total) begin
            i_next = total_reg;
        end
        if (cmd.i_clear) begin
            i_next = '0;
        end
        if (cmd.i_inc) begin
            i_next = i_reg + ONE_C;
        end
        if (cmd.set_clear) begin
            fill_next = '0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg  <= total_next;
        heap_n_reg <= heap_n_next;
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        if (cmd.out_load) begin
            m_key_reg      <= 64'(rd_a_reg);
            m_final_reg    <= stat.final_item;
            m_overflow_reg <= drop_reg;
        end
    end

    assign m_key      = m_key_reg;
    assign m_final    = m_final_reg;
    assign m_overflow = m_overflow_reg;

endmodule

`default_nettype wire

// ----- rtl/heap_sort_engine_unit.sv -----
`default_nettype none

// Channel   Direction  Word contents (lowest bit first)
// s_        in         tdata: key[63:0]; tlast: last key of the set
// m_        out        tdata: sorted_key[63:0]; tlast: final_res; tuser: overflow
//
// Loading accepts one word per cycle. After the last word the block sorts in place
// in a memory with two read ports and one write port: each sift level reads both
// children, then compares and writes, and each heap node or extraction adds a read
// and then a load or swap. Each result is then read, loaded and held until taken.
// No word is accepted between the last input word and the hand-off of the final
// result. Reset clears the fill count and the overflow flag; the memory holds no
// reset value and needs no clearing pass.

module heap_sort_engine_unit #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // sorted_key
    output logic             m_tlast,
    output logic             m_tuser    // overflow
);
    import hse_pkg::*;

    hse_cmd_t  cmd;
    hse_stat_t stat;

    hse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hse_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_key      (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_key      (m_tdata),
        .m_final    (m_tlast),
        .m_overflow (m_tuser)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam logic [63:0] KEY_MASK =
        (KEY_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 2500;
    localparam int TAIL_CYCLES = 50;
    localparam int FEED_TARGET = 350;

    typedef struct {
        logic [63:0] key;
        logic        last;
        int          gap;
        logic        drain;
    } feed_word_t;

    typedef struct {
        logic [63:0] key;
        logic        fin;
        logic        ovf;
    } sorted_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    feed_word_t   key_feed[$];
    sorted_word_t sorted_due[$];
    logic [63:0]  set_keys[$];
    logic         set_dropped = 1'b0;

    logic         in_fire   = 1'b0;
    logic         out_fire  = 1'b0;
    logic         rx_steady = 1'b0;
    logic         hold_off  = 1'b0;
    int           keys_taken = 0;
    int           hold_at    = 32'h7FFF_FFFF;
    int           feed_idle  = 0;
    int           rx_wait    = 0;
    int           errors     = 0;
    int           cycles     = 0;
    feed_word_t   next_word;
    sorted_word_t due_word;

    heap_sort_engine_unit #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // key
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // sorted_key
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)     // overflow
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Keeps the current set in ascending order as keys arrive, and releases the
    // whole set as expected words when the last key is taken.
    task automatic take_key(input logic [63:0] raw, input logic last);
        sorted_word_t w;
        logic [63:0]  t;
        int           j;
        if (set_keys.size() < CAPACITY) begin
            set_keys.insert(set_keys.size(), raw & KEY_MASK);
            j = set_keys.size() - 1;
            while (j > 0 && set_keys[j - 1] > set_keys[j]) begin
                t = set_keys[j];
                set_keys[j] = set_keys[j - 1];
                set_keys[j - 1] = t;
                j = j - 1;
            end
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < set_keys.size(); k++) begin
                w.key = set_keys[k];
                w.fin = (k == set_keys.size() - 1);
                w.ovf = set_dropped;
                sorted_due.insert(sorted_due.size(), w);
            end
            set_keys.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic add_word(input logic [63:0] key, input logic last, input int gap,
                            input logic drain);
        feed_word_t w;
        w.key = key;
        w.last = last;
        w.gap = gap;
        w.drain = drain;
        key_feed.insert(key_feed.size(), w);
    endtask

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        int          len;
        k = '0;
        case ($urandom_range(0, 3))
            0: k = {$urandom, $urandom};
            1: begin
                len = $urandom_range(1, 8);
                for (int b = 0; b < 8; b++) begin
                    k = {k[55:0], (b < len) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'h00};
                end
            end
            2: k = 64'($urandom_range(0, 7));
            default: begin
                case ($urandom_range(0, 3))
                    0: k = 64'h0;
                    1: k = 64'hFFFF_FFFF_FFFF_FFFF;
                    2: k = 64'h8000_0000_0000_0000;
                    default: k = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
        endcase
        return k;
    endfunction

    task automatic add_set(input int count, input logic steady, input logic drain);
        for (int i = 0; i < count; i++) begin
            add_word(pick_key(), i == count - 1, steady ? 0 : $urandom_range(0, 5),
                     drain && i == 0);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            feed_idle = 0;
        end else if (!s_tvalid || in_fire) begin
            if (key_feed.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                next_word = key_feed[0];
                if (next_word.drain && sorted_due.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (feed_idle < next_word.gap) begin
                    feed_idle = feed_idle + 1;
                    s_tvalid <= 1'b0;
                end else begin
                    void'(key_feed.pop_front());
                    feed_idle = 0;
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.key;
                    s_tlast <= next_word.last;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_fire) begin
                rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        out_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            take_key(s_tdata, s_tlast);
            keys_taken <= keys_taken + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tlast) begin
                rx_steady <= ($urandom_range(0, 3) == 0);
            end
            if (sorted_due.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) begin
                    $display("unexpected word: key %h last %b overflow %b",
                             m_tdata, m_tlast, m_tuser);
                end
            end else begin
                due_word = sorted_due.pop_front();
                if (m_tdata !== due_word.key || m_tlast !== due_word.fin
                        || m_tuser !== due_word.ovf) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("mismatch: key %h/%h last %b/%b overflow %b/%b (exp/act)",
                                 due_word.key, m_tdata, due_word.fin, m_tlast,
                                 due_word.ovf, m_tuser);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // The receiver stops for a long stretch while a full set is being loaded, so the
    // block finishes sorting, stalls on its output and then holds off its input.
    initial begin
        wait (keys_taken >= hold_at);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int sets;
        int count;

        add_word(64'h0, 1'b1, 0, 1'b0);
        add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2, 1'b0);
        add_word(64'h6162_6300_0000_0000, 1'b0, 0, 1'b0);
        add_word(64'h6162_6300_0000_0000, 1'b0, 1, 1'b0);
        add_word(64'h6162_6300_0000_0000, 1'b1, 0, 1'b0);
        add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3, 1'b1);
        add_word(64'h0, 1'b0, 0, 1'b0);
        add_word(64'h8000_0000_0000_0000, 1'b0, 5, 1'b0);
        add_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0, 1'b0);
        add_word(64'h1, 1'b0, 0, 1'b0);
        add_word(64'h6162_0000_0000_0000, 1'b0, 4, 1'b0);
        add_word(64'h6162_6300_0000_0000, 1'b1, 0, 1'b0);
        add_word(64'h5555_5555_5555_5555, 1'b0, 0, 1'b0);
        add_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1, 1'b0);
        add_word(64'h3, 1'b0, 0, 1'b0);
        add_word(64'h2, 1'b0, 0, 1'b0);
        add_word(64'h1, 1'b1, 2, 1'b0);

        sets = 0;
        while (key_feed.size() < FEED_TARGET) begin
            if (sets == 3) begin
                hold_at = key_feed.size();
                add_set(CAPACITY, 1'b0, 1'b0);
            end else if (sets == 4) begin
                add_set($urandom_range(1, 8), 1'b0, 1'b0);
            end else if (sets == 6) begin
                add_set(CAPACITY + 2, 1'b0, 1'b0);
            end else begin
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                                                    : $urandom_range(1, 12);
                add_set(count, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
            end
            sets = sets + 1;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (key_feed.size() != 0 || s_tvalid) @(posedge aclk);
        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && sorted_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
